[rtl/core/mffp_pkg.sv]
// mffp_pkg: shared types, constants and the crc byte step for the
// motor feedback frame parser; no dependencies
package mffp_pkg;

    // frame layout
    localparam int FRAME_BYTES     = 10;
    localparam int WIN_DEPTH       = FRAME_BYTES - 1;
    localparam int FILL_W          = $clog2(WIN_DEPTH + 1);
    localparam int MOTOR_COUNT_DEF = 2;

    // crc-8/maxim, reflected form
    localparam logic [7:0] CRC_POLY = 8'h8C;

    // opcodes
    localparam logic [7:0] READ_OP_RESET = 8'hA1;
    localparam logic [7:0] ALT_BASIC_OP  = 8'h65;
    localparam logic [7:0] EXT_OP        = 8'h75;

    // frame kinds
    localparam logic KIND_BASIC = 1'b0;
    localparam logic KIND_EXT   = 1'b1;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // payload bytes 2..8 kept per matched frame
    localparam int KEEP_BYTES = WIN_DEPTH - 2;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       burst_start;
    } mffp_item_t;

    typedef struct packed {
        logic [1:0]        motor_id;
        logic              frame_kind;
        logic signed [15:0] speed;
        logic signed [15:0] current;
        logic [7:0]        temperature;
        logic [7:0]        fault_code;
        logic signed [31:0] turn_count;
        logic [15:0]       angle_position;
    } mffp_result_t;

    // one classified frame; data[0] is frame byte 2
    typedef struct packed {
        logic                        frame_kind;
        logic [1:0]                  motor_id;
        logic [KEEP_BYTES-1:0][7:0]  data;
    } mffp_entry_t;

    typedef struct packed {
        logic        push;
        mffp_entry_t entry;
    } mffp_push_t;

    // one byte through the reflected crc
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

[rtl/core/motor_feedback_frame_parser_core.sv]
// motor_feedback_frame_parser_core: top level of the frame parser
// depends on mffp_pkg, mffp_front, mffp_queue, mffp_back
//
// channel   handshake              payload
// -------   ---------------------  --------------------------------------
// input     push / full            item   (rx_byte, burst_start)
// result    empty / pop            result (decoded frame record)
// config    cfg_we                 cfg_wdata (read opcode)
//
// one byte is taken every cycle while full is low; the crc of the nine-byte window
// comes from nine running crc lanes, each advanced by one byte step per accepted byte.
// a matching frame is written to the queue at the edge that takes its check
// byte and is loaded into the output register once that register is free or popped.
// full rises only when the four-entry frame queue fills while pop is held off.
// reset clears the window fill count, queue and output valid; read opcode 0xA1.
module motor_feedback_frame_parser_core
    import mffp_pkg::*;
#(
    parameter int MOTOR_COUNT = MOTOR_COUNT_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    output logic         full,
    input  mffp_item_t   item,
    output logic         empty,
    input  logic         pop,
    output mffp_result_t result,
    input  logic         cfg_we,
    input  logic [7:0]   cfg_wdata
);

    logic        accept;
    mffp_push_t  qpush;
    logic        q_valid, q_pop;
    mffp_entry_t q_entry;

    assign accept = push && !full;

    // front: window and classification
    mffp_front #(
        .MOTOR_COUNT(MOTOR_COUNT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .qpush     (qpush)
    );

    // frame queue
    mffp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .qpush    (qpush),
        .rd_en    (q_pop),
        .full     (full),
        .rd_valid (q_valid),
        .rd_entry (q_entry)
    );

    // back: decode and output register
    mffp_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_entry (q_entry),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .result  (result)
    );

endmodule

[rtl/core/mffp_front.sv]
// mffp_front: byte window, sliding crc lanes, opcode register and frame test
// depends on mffp_pkg
module mffp_front
    import mffp_pkg::*;
#(
    parameter int MOTOR_COUNT = MOTOR_COUNT_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  mffp_item_t item,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    output mffp_push_t qpush
);

    logic [7:0]                 read_op_reg;
    logic [FILL_W-1:0]          fill_reg, fill_next, fill_eff;
    logic [WIN_DEPTH-1:0][7:0]  win_reg, win_next;
    logic [WIN_DEPTH-1:0][7:0]  lane_reg, lane_next;
    logic                       full_win, crc_ok, id_ok, is_basic, is_ext;
    logic [7:0]                 id_byte, op_byte;

    // window content seen by this byte
    assign fill_eff = item.burst_start ? '0 : fill_reg;
    assign full_win = (fill_eff >= FILL_W'(WIN_DEPTH));
    assign id_byte  = win_reg[0];
    assign op_byte  = win_reg[1];

    // frame test: lane of the oldest start holds the crc of all nine bytes
    assign crc_ok   = (lane_reg[WIN_DEPTH-1] == item.rx_byte);
    assign id_ok    = (id_byte != 8'd0) && (id_byte <= 8'(MOTOR_COUNT));
    assign is_basic = (op_byte == read_op_reg) || (op_byte == ALT_BASIC_OP);
    assign is_ext   = (op_byte == EXT_OP);

    // classified frame toward the queue
    always_comb
    begin
        qpush.push             = accept && full_win && crc_ok && id_ok && (is_basic || is_ext);
        qpush.entry.frame_kind = is_basic ? KIND_BASIC : KIND_EXT;
        qpush.entry.motor_id   = id_byte[1:0];
        for (int i = 0; i < KEEP_BYTES; i++)
        begin
            qpush.entry.data[i] = win_reg[i+2];
        end
    end

    // shift window and advance every crc lane by the new byte
    always_comb
    begin
        for (int i = 0; i < WIN_DEPTH - 1; i++)
        begin
            win_next[i] = win_reg[i+1];
        end
        win_next[WIN_DEPTH-1] = item.rx_byte;
        lane_next[0] = crc8_step(8'd0, item.rx_byte);
        for (int j = 1; j < WIN_DEPTH; j++)
        begin
            lane_next[j] = crc8_step(lane_reg[j-1], item.rx_byte);
        end
        fill_next = (fill_eff < FILL_W'(WIN_DEPTH)) ? fill_eff + 1'b1 : FILL_W'(WIN_DEPTH);
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg    <= '0;
            read_op_reg <= READ_OP_RESET;
        end
        else
        begin
            if (accept)
            begin
                fill_reg <= fill_next;
            end
            if (cfg_we)
            begin
                read_op_reg <= cfg_wdata;
            end
        end
    end

    // window bytes and crc lanes
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            win_reg  <= win_next;
            lane_reg <= lane_next;
        end
    end

`ifndef SYNTH
    // a frame is never found in a short or freshly restarted burst
    assert property (@(posedge clk) disable iff (!rst_n)
        qpush.push |-> (!item.burst_start && fill_reg >= FILL_W'(WIN_DEPTH)))
        else $error("frame pushed without a full window");

    // fill count saturates at the window depth
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(WIN_DEPTH))
        else $error("fill count beyond window depth");
`endif

endmodule

[rtl/core/mffp_queue.sv]
// mffp_queue: short fifo of classified frames between front and back
// depends on mffp_pkg
module mffp_queue
    import mffp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  mffp_push_t  qpush,
    input  logic        rd_en,
    output logic        full,
    output logic        rd_valid,
    output mffp_entry_t rd_entry
);

    mffp_entry_t        mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               do_wr, do_rd;

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign do_wr    = qpush.push;
    assign do_rd    = rd_en && rd_valid;
    assign rd_entry = mem[rd_ptr_reg];

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_wr && do_rd)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= qpush.entry;
        end
    end

`ifndef SYNTH
    // no write while full
    assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !do_wr)
        else $error("queue overflow");

    // occupancy stays in range
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");
`endif

endmodule

[rtl/core/mffp_back.sv]
// mffp_back: decodes a classified frame into a result record and holds it
// in the output register; depends on mffp_pkg
module mffp_back
    import mffp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         q_valid,
    input  mffp_entry_t  q_entry,
    output logic         q_pop,
    input  logic         pop,
    output logic         empty,
    output mffp_result_t result
);

    logic         out_valid_reg;
    mffp_result_t out_reg, out_next;

    assign empty  = !out_valid_reg;
    assign result = out_reg;
    assign q_pop  = q_valid && (!out_valid_reg || pop);

    // field decode, unused fields zero
    always_comb
    begin
        out_next            = '0;
        out_next.motor_id   = q_entry.motor_id;
        out_next.frame_kind = q_entry.frame_kind;
        out_next.fault_code = q_entry.data[6];
        if (q_entry.frame_kind == KIND_BASIC)
        begin
            out_next.speed       = {q_entry.data[0], q_entry.data[1]};
            out_next.current     = {q_entry.data[2], q_entry.data[3]};
            out_next.temperature = q_entry.data[5];
        end
        else
        begin
            out_next.turn_count     = {q_entry.data[0], q_entry.data[1],
                                       q_entry.data[2], q_entry.data[3]};
            out_next.angle_position = {q_entry.data[4], q_entry.data[5]};
        end
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (q_pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output record
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            out_reg <= out_next;
        end
    end

`ifndef SYNTH
    // a result appears only from a queued frame
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(q_valid))
        else $error("result without queued frame");
`endif

endmodule

[tb/sv/motor_feedback_frame_parser_core_test.sv]
// motor_feedback_frame_parser_core_test: self-checking bench for the motor feedback frame parser
// depends on mffp_pkg and motor_feedback_frame_parser_core; drives byte streams with crc-correct
// frames, noise and broken frames, predicts the decoded records and checks them word by word
module motor_feedback_frame_parser_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mffp_pkg::*;

    localparam int MOTORS     = MOTOR_COUNT_DEF;
    localparam int WINDOW     = 9;
    localparam int IDLE_LIMIT = 1000;
    localparam int PHASE_LEN  = 130;
    localparam int RANDOM_PAT = -1;

    // receiver stall modes
    localparam int POP_ALWAYS = 0;
    localparam int POP_COIN   = 1;
    localparam int POP_SPARSE = 2;
    localparam int POP_HOLD   = 3;

    logic         clk       = 1'b0;
    logic         rst_n     = 1'b0;
    logic         push      = 1'b0;
    logic         full;
    mffp_item_t   item      = '0;
    logic         empty;
    logic         pop       = 1'b0;
    mffp_result_t result;
    logic         cfg_we    = 1'b0;
    logic [7:0]   cfg_wdata = 8'h00;

    // predictor state: receive window, fill level and the read opcode
    logic [7:0]   win_bytes [0:WINDOW-1];
    int           win_fill;
    logic [7:0]   model_read_op;

    mffp_item_t   byte_queue [$];
    mffp_result_t expected_records [$];
    mffp_result_t head_record;
    mffp_item_t   next_word;
    int           queued_count = 0;
    int           taken_count  = 0;
    int           error_count  = 0;
    int           idle_cycles  = 0;
    int           burst_left   = 0;
    int           gap_left     = 0;
    int           pop_mode     = POP_ALWAYS;
    int           pop_left     = 0;
    int           phase;
    int           target;
    int           roll;
    logic [7:0]   phase_op;

    motor_feedback_frame_parser_core #(
        .MOTOR_COUNT (MOTORS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // crc-8/maxim over nine bytes, byte 0 in the low bits
    function automatic logic [7:0] maxim_crc9(input logic [71:0] bytes9);
        logic [7:0] crc;
        crc = 8'h00;
        for (int i = 0; i < WINDOW; i++)
        begin
            crc = crc ^ bytes9[8*i +: 8];
            for (int k = 0; k < 8; k++)
            begin
                crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
            end
        end
        return crc;
    endfunction

    // advance the window by one accepted byte and queue any decoded record
    task automatic decode_rx_byte(input mffp_item_t w);
        logic [71:0]  frame;
        mffp_result_t rec;
        if (w.burst_start)
            win_fill = 0;
        if (win_fill >= WINDOW)
        begin
            for (int i = 0; i < WINDOW; i++)
                frame[8*i +: 8] = win_bytes[i];
            if (maxim_crc9(frame) == w.rx_byte && win_bytes[0] >= 8'd1 &&
                win_bytes[0] <= MOTORS)
            begin
                rec            = '0;
                rec.motor_id   = win_bytes[0][1:0];
                rec.fault_code = win_bytes[8];
                if (win_bytes[1] == model_read_op || win_bytes[1] == ALT_BASIC_OP)
                begin
                    rec.frame_kind  = KIND_BASIC;
                    rec.speed       = {win_bytes[2], win_bytes[3]};
                    rec.current     = {win_bytes[4], win_bytes[5]};
                    rec.temperature = win_bytes[7];
                    expected_records.push_back(rec);
                end
                else if (win_bytes[1] == EXT_OP)
                begin
                    rec.frame_kind     = KIND_EXT;
                    rec.turn_count     = {win_bytes[2], win_bytes[3], win_bytes[4], win_bytes[5]};
                    rec.angle_position = {win_bytes[6], win_bytes[7]};
                    expected_records.push_back(rec);
                end
            end
        end
        for (int i = 0; i < WINDOW - 1; i++)
            win_bytes[i] = win_bytes[i+1];
        win_bytes[WINDOW-1] = w.rx_byte;
        if (win_fill < WINDOW)
            win_fill++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            error_count++;
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    task automatic add_byte(input logic [7:0] value, input logic fresh);
        mffp_item_t w;
        w.rx_byte     = value;
        w.burst_start = fresh;
        byte_queue.push_back(w);
        queued_count++;
    endtask

    // payload bytes lean toward the extremes of the decoded fields
    function automatic logic [7:0] payload_byte(input int pat);
        if (pat != RANDOM_PAT)
            return pat[7:0];
        case ($urandom_range(0, 5))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h80;
            3: return 8'h7F;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] pick_op();
        case ($urandom_range(0, 2))
            0: return model_read_op;
            1: return ALT_BASIC_OP;
            default: return EXT_OP;
        endcase
    endfunction

    // one frame with its check byte, possibly corrupted or cut short
    task automatic add_frame(input logic [7:0] id, input logic [7:0] op, input logic fresh,
                             input logic corrupt, input int keep, input int pat);
        logic [71:0] body;
        logic [7:0]  check;
        body[7:0]  = id;
        body[15:8] = op;
        for (int i = 2; i < WINDOW; i++)
            body[8*i +: 8] = payload_byte(pat);
        check = maxim_crc9(body);
        if (corrupt)
            check = check ^ (8'h01 << $urandom_range(0, 7));
        for (int i = 0; i < keep; i++)
            add_byte((i < WINDOW) ? body[8*i +: 8] : check, fresh && i == 0);
    endtask

    // sender holds off until every byte is taken and every record has come back
    task automatic wait_drained();
        while (taken_count != queued_count || expected_records.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_read_op(input logic [7:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we        <= 1'b0;
        model_read_op  = value;
    endtask

    // input driver: bursts of random length with random gaps
    always @(posedge clk)
    begin
        if (rst_n && push && !full)
        begin
            decode_rx_byte(item);
            taken_count++;
        end
        if (!rst_n)
        begin
            push <= 1'b0;
        end
        else if (!push || !full)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                push <= 1'b0;
            end
            else if (byte_queue.size() > 0)
            begin
                next_word = byte_queue.pop_front();
                item <= next_word;
                push <= 1'b1;
                if (burst_left > 1)
                begin
                    burst_left--;
                end
                else
                begin
                    burst_left = $urandom_range(1, 48);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                end
            end
            else
            begin
                push <= 1'b0;
            end
        end
    end

    // result monitor and receiver stall pattern
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (expected_records.size() == 0)
            begin
                error_count++;
                $display("%0t ns: unexpected result word, expected none, actual %h",
                         $time, result);
            end
            else
            begin
                head_record = expected_records.pop_front();
                compare_field("motor_id", head_record.motor_id, result.motor_id);
                compare_field("frame_kind", head_record.frame_kind, result.frame_kind);
                compare_field("speed", head_record.speed, result.speed);
                compare_field("current", head_record.current, result.current);
                compare_field("temperature", head_record.temperature, result.temperature);
                compare_field("fault_code", head_record.fault_code, result.fault_code);
                compare_field("turn_count", head_record.turn_count, result.turn_count);
                compare_field("angle_position", head_record.angle_position,
                              result.angle_position);
            end
        end
        if (pop_left == 0)
        begin
            pop_mode = $urandom_range(POP_ALWAYS, POP_HOLD);
            pop_left = (pop_mode == POP_HOLD) ? $urandom_range(4, 20) : $urandom_range(8, 64);
        end
        pop_left--;
        case (pop_mode)
            POP_ALWAYS: pop <= 1'b1;
            POP_COIN:   pop <= 1'($urandom_range(0, 1));
            POP_SPARSE: pop <= ($urandom_range(0, 3) == 0);
            default:    pop <= 1'b0;
        endcase
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // stimulus sequence
    initial
    begin
        for (int i = 0; i < WINDOW; i++)
            win_bytes[i] = 8'h00;
        win_fill      = 0;
        model_read_op = READ_OP_RESET;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: short burst, then one frame of each opcode with extreme payloads
        add_frame(8'd1, READ_OP_RESET, 1'b1, 1'b0, 3, 8'hFF);
        add_frame(8'd1, READ_OP_RESET, 1'b1, 1'b0, 10, 8'hFF);
        add_frame(8'(MOTORS), EXT_OP, 1'b0, 1'b0, 10, 8'h80);
        add_frame(8'd1, ALT_BASIC_OP, 1'b0, 1'b0, 10, 8'h00);
        wait_drained();

        // random phases, each under its own read opcode
        for (phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: phase_op = READ_OP_RESET;
                1: phase_op = 8'h00;
                2: phase_op = 8'hFF;
                3: phase_op = EXT_OP;
                4: phase_op = ALT_BASIC_OP;
                default: phase_op = 8'($urandom_range(0, 255));
            endcase
            if (phase > 0)
                write_read_op(phase_op);
            target = queued_count + PHASE_LEN;
            while (queued_count < target)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 55)
                begin
                    // well-formed frame, sometimes starting a new burst
                    add_frame(8'($urandom_range(1, MOTORS)), pick_op(),
                              1'($urandom_range(0, 1)), 1'b0, 10, RANDOM_PAT);
                end
                else if (roll < 67)
                begin
                    // bad id, unknown opcode or broken check byte
                    add_frame(($urandom_range(0, 1) == 0) ? 8'd0 :
                                  8'($urandom_range(MOTORS + 1, 255)),
                              ($urandom_range(0, 1) == 0) ? pick_op() :
                                  8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              10, RANDOM_PAT);
                    add_frame(8'($urandom_range(1, MOTORS)), pick_op(), 1'b0, 1'b1,
                              10, RANDOM_PAT);
                end
                else if (roll < 77)
                begin
                    // frame cut short by the next burst
                    add_frame(8'($urandom_range(1, MOTORS)), pick_op(), 1'b1, 1'b0,
                              $urandom_range(1, 9), RANDOM_PAT);
                end
                else
                begin
                    // line noise
                    repeat ($urandom_range(1, 12))
                        add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
                end
            end
            wait_drained();
        end

        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[motor_feedback_frame_parser_core.f]
rtl/core/mffp_pkg.sv
rtl/core/mffp_front.sv
rtl/core/mffp_queue.sv
rtl/core/mffp_back.sv
rtl/core/motor_feedback_frame_parser_core.sv
tb/sv/motor_feedback_frame_parser_core_test.sv
